FILE: rtl/core/ttc_pkg.sv
package ttc_pkg;

   // Fixed-point scaling of gaps, speeds, accelerations and times.
   localparam int FRAC_BITS  = 8;
   // Extra fraction bits carried into the square root of the discriminant.
   localparam int GUARD_BITS = 8;

   // Field widths.
   localparam int GAP_W   = 16;
   localparam int SPD_W   = 14;
   localparam int ACC_W   = 13;
   localparam int TIME_W  = 16;

   // Discriminant numerator, its divisor and the scaled quotient.
   localparam int QN_W = 43;
   localparam int QD_W = 13;
   localparam int Q_W  = QN_W + 2 * GUARD_BITS;
   localparam int SQ_W = (Q_W + 1) / 2;

   // Final divide operands and the root-path speed and acceleration.
   localparam int X_W = 38;
   localparam int Y_W = 27;
   localparam int V_W = 15;
   localparam int A_W = 14;

   // How an item is finished after the front end has classified it.
   localparam logic [1:0] MODE_INF    = 2'd0;
   localparam logic [1:0] MODE_DIRECT = 2'd1;
   localparam logic [1:0] MODE_ROOT   = 2'd2;

   typedef struct packed {
      logic [1:0]            mode;
      logic signed [V_W-1:0] v;
      logic [A_W-1:0]        a;
      logic [X_W-1:0]        x;
      logic [Y_W-1:0]        y;
   } side_type;

endpackage

FILE: rtl/core/ttc_front.sv
module ttc_front import ttc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [GAP_W-1:0]  in_gap,
   input  logic [SPD_W-1:0]  in_vo,
   input  logic signed [ACC_W-1:0] in_ao,
   input  logic [SPD_W-1:0]  in_ve,
   input  logic signed [ACC_W-1:0] in_ae,
   input  logic [GAP_W-1:0]  in_sb,
   output logic              out_valid,
   output logic [QN_W-1:0]   out_qnum,
   output logic [QD_W-1:0]   out_qden,
   output side_type          out_side
);

   localparam int S_W = 46;

   typedef struct packed {
      logic ego_stop;
      logic noclose;
      logic rdneg;
      logic brake;
      logic vo_gt1;
      logic rvneg;
      logic ae_zero;
      logic ae_lt1;
      logic ve_le1;
      logic ra_lt1;
   } flag_type;

   logic [5:0] valid_ff;

   // Stage 0: captured inputs.
   logic [GAP_W-1:0] gap_s0_ff, sb_s0_ff;
   logic [SPD_W-1:0] vo_s0_ff, ve_s0_ff;
   logic signed [ACC_W-1:0] ao_s0_ff, ae_s0_ff;

   // Stage 1: differences and case flags.
   logic signed [ACC_W-1:0] ao_adj;
   logic signed [14:0] rv_s1_in, rv_s1_ff;
   logic signed [16:0] rd_s1_in, rd_s1_ff;
   logic signed [13:0] ra_s1_in, ra_s1_ff, b_s1_in, b_s1_ff;
   logic [12:0]        am_s1_in, am_s1_ff;
   flag_type           flag_s1_in, flag_s1_ff;
   logic [SPD_W-1:0]   vo_s1_ff, ve_s1_ff;
   logic signed [ACC_W-1:0] ao_s1_ff, ae_s1_ff;
   logic [GAP_W-1:0]   sb_s1_ff;

   // Stage 2: first products.
   logic [27:0]        vovo_s2_in, veve_s2_in, vevo_s2_in;
   logic [27:0]        vovo_s2_ff, veve_s2_ff, vevo_s2_ff;
   logic [26:0]        amve_s2_in, amve_s2_ff;
   logic signed [27:0] aevo_s2_in, aevo_s2_ff, veao_s2_in, veao_s2_ff;
   logic [28:0]        sbam_s2_in, sbam_s2_ff;
   logic signed [30:0] rdam_s2_in, rdam_s2_ff, rard_s2_in, rard_s2_ff;
   logic signed [29:0] rvrv_s2_in, rvrv_s2_ff;
   logic signed [27:0] bb_s2_in, bb_s2_ff;
   logic signed [ACC_W-1:0] ao_s2_ff, ae_s2_ff;
   logic [12:0]        am_s2_ff;
   logic signed [13:0] b_s2_ff, ra_s2_ff;
   logic signed [16:0] rd_s2_ff;
   logic signed [14:0] rv_s2_ff;
   logic [SPD_W-1:0]   ve_s2_ff;
   flag_type           flag_s2_ff;

   // Stage 3: second products.
   logic [40:0]        t1_in, t1_ff, t3_in, t3_ff, t5_in, t5_ff;
   logic signed [41:0] t2_in, t2_ff, t9_in, t9_ff;
   logic [41:0]        t4_in, t4_ff;
   logic signed [43:0] t6_in, t6_ff;
   logic signed [42:0] t7_in, t7_ff, t8_in, t8_ff;
   logic signed [44:0] t10_in, t10_ff;
   logic               ovt_s3_in, ovt_s3_ff;
   logic signed [32:0] dq2_s3_in, dq2_s3_ff;
   logic [32:0]        ennum_s3_in, ennum_s3_ff;
   logic [Y_W-1:0]     amve2_s3_in, amve2_s3_ff;
   flag_type           flag_s3_ff;
   logic signed [16:0] rd_s3_ff;
   logic signed [14:0] rv_s3_ff;
   logic signed [13:0] ra_s3_ff;
   logic [SPD_W-1:0]   ve_s3_ff;
   logic signed [ACC_W-1:0] ae_s3_ff;
   logic [12:0]        am_s3_ff;

   // Stage 4: sums for the comparisons and the discriminant.
   logic signed [S_W-1:0] lhs_in, lhs_ff, rhs_in, rhs_ff, dq1_in, dq1_ff;
   logic signed [S_W-1:0] blhs_in, blhs_ff, brhs_in, brhs_ff;
   logic signed [32:0] dq2_s4_ff;
   logic [32:0]        ennum_s4_ff;
   logic [Y_W-1:0]     amve2_s4_ff;
   flag_type           flag_s4_ff;
   logic               ovt_s4_ff;
   logic signed [16:0] rd_s4_ff;
   logic signed [14:0] rv_s4_ff;
   logic signed [13:0] ra_s4_ff;
   logic [SPD_W-1:0]   ve_s4_ff;
   logic signed [ACC_W-1:0] ae_s4_ff;
   logic [12:0]        am_s4_ff;

   // Stage 5: case selection.
   logic [QN_W-1:0]    qnum_in, qnum_ff;
   logic [QD_W-1:0]    qden_in, qden_ff;
   side_type           side_in, side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // Stage 1 logic.
   assign ao_adj   = (vo_s0_ff == '0 && ao_s0_ff[ACC_W-1]) ? '0 : ao_s0_ff;
   assign rv_s1_in = $signed({1'b0, ve_s0_ff}) - $signed({1'b0, vo_s0_ff});
   assign rd_s1_in = $signed({1'b0, gap_s0_ff}) - $signed({1'b0, sb_s0_ff});
   assign ra_s1_in = $signed({ae_s0_ff[ACC_W-1], ae_s0_ff})
                   - $signed({ao_adj[ACC_W-1], ao_adj});
   assign am_s1_in = ao_adj[ACC_W-1] ? 13'(14'd0 - {ao_adj[ACC_W-1], ao_adj}) : '0;
   assign b_s1_in  = 14'sd0 - $signed({ae_s0_ff[ACC_W-1], ae_s0_ff});

   always_comb begin
      flag_s1_in.ego_stop = (ve_s0_ff == '0) && (ae_s0_ff[ACC_W-1] || ae_s0_ff == '0);
      flag_s1_in.noclose  = (ra_s1_in <= 14'sd1) && (rv_s1_in <= 15'sd0);
      flag_s1_in.rdneg    = rd_s1_in[16];
      flag_s1_in.brake    = ao_adj[ACC_W-1];
      flag_s1_in.vo_gt1   = vo_s0_ff > 14'd1;
      flag_s1_in.rvneg    = rv_s1_in[14];
      flag_s1_in.ae_zero  = ae_s0_ff == '0;
      flag_s1_in.ae_lt1   = ae_s0_ff[ACC_W-1] || ae_s0_ff == '0;
      flag_s1_in.ve_le1   = ve_s0_ff <= 14'd1;
      flag_s1_in.ra_lt1   = ra_s1_in < 14'sd1;
   end

   // Stage 2 logic.
   assign vovo_s2_in = vo_s1_ff * vo_s1_ff;
   assign veve_s2_in = ve_s1_ff * ve_s1_ff;
   assign vevo_s2_in = ve_s1_ff * vo_s1_ff;
   assign amve_s2_in = am_s1_ff * ve_s1_ff;
   assign aevo_s2_in = ae_s1_ff * $signed({1'b0, vo_s1_ff});
   assign veao_s2_in = $signed({1'b0, ve_s1_ff}) * ao_s1_ff;
   assign sbam_s2_in = sb_s1_ff * am_s1_ff;
   assign rdam_s2_in = rd_s1_ff * $signed({1'b0, am_s1_ff});
   assign rvrv_s2_in = rv_s1_ff * rv_s1_ff;
   assign rard_s2_in = ra_s1_ff * rd_s1_ff;
   assign bb_s2_in   = b_s1_ff * b_s1_ff;

   // Stage 3 logic.
   assign t1_in  = vevo_s2_ff * am_s2_ff;
   assign t2_in  = ae_s2_ff * $signed({1'b0, vovo_s2_ff});
   assign t3_in  = vovo_s2_ff * am_s2_ff;
   assign t4_in  = sbam_s2_ff * am_s2_ff;
   assign t5_in  = veve_s2_ff * am_s2_ff;
   assign t6_in  = ae_s2_ff * rdam_s2_ff;
   assign t7_in  = $signed({1'b0, veve_s2_ff}) * b_s2_ff;
   assign t8_in  = $signed({1'b0, vevo_s2_ff}) * b_s2_ff;
   assign t9_in  = ao_s2_ff * $signed({1'b0, veve_s2_ff});
   assign t10_in = rd_s2_ff * bb_s2_ff;
   assign ovt_s3_in   = aevo_s2_ff > veao_s2_ff;
   assign dq2_s3_in   = $signed({{3{rvrv_s2_ff[29]}}, rvrv_s2_ff})
                      + $signed({rard_s2_ff[30], rard_s2_ff, 1'b0});
   assign ennum_s3_in = {rdam_s2_ff[30], rdam_s2_ff, 1'b0} + {5'b0, vovo_s2_ff};
   assign amve2_s3_in = {amve_s2_ff[Y_W-2:0], 1'b0};

   // Stage 4 logic.
   assign lhs_in  = (S_W'($signed({1'b0, t1_ff})) <<< 1) + S_W'(t2_ff);
   assign rhs_in  = S_W'($signed({1'b0, t3_ff})) + (S_W'($signed({1'b0, t4_ff})) <<< 1);
   assign dq1_in  = S_W'($signed({1'b0, t5_ff})) + (S_W'(t6_ff) <<< 1) + S_W'(t2_ff);
   assign blhs_in = S_W'(t7_ff);
   assign brhs_in = (S_W'(t8_ff) <<< 1) + S_W'(t9_ff) + (S_W'(t10_ff) <<< 1);

   // Stage 5 logic: pick how the item is finished.
   always_comb begin
      logic fall;
      fall         = 1'b0;
      qnum_in      = '0;
      qden_in      = QD_W'(1);
      side_in.mode = MODE_INF;
      side_in.v    = '0;
      side_in.a    = '0;
      side_in.x    = '0;
      side_in.y    = Y_W'(1);
      priority if (flag_s4_ff.ego_stop || flag_s4_ff.noclose) begin
         side_in.mode = MODE_INF;
      end else if (flag_s4_ff.rdneg) begin
         side_in.mode = MODE_DIRECT;
      end else if (flag_s4_ff.brake && flag_s4_ff.vo_gt1 && ovt_s4_ff) begin
         if (lhs_ff < rhs_ff) begin
            if (flag_s4_ff.ae_lt1) begin
               if (!flag_s4_ff.ve_le1) begin
                  side_in.mode = MODE_DIRECT;
                  side_in.x    = X_W'(ennum_s4_ff[29:0]) << FRAC_BITS;
                  side_in.y    = amve2_s4_ff;
               end
            end else if (dq1_ff > 0) begin
               side_in.mode = MODE_ROOT;
               qnum_in      = dq1_ff[QN_W-1:0];
               qden_in      = am_s4_ff;
               side_in.v    = $signed({1'b0, ve_s4_ff});
               side_in.a    = {1'b0, ae_s4_ff[ACC_W-1:0]};
            end
         end else begin
            fall = 1'b1;
         end
      end else if (flag_s4_ff.brake && flag_s4_ff.rvneg && !flag_s4_ff.ae_zero) begin
         fall = !(blhs_ff < brhs_ff);
      end else begin
         fall = 1'b1;
      end
      if (fall) begin
         if (flag_s4_ff.ra_lt1) begin
            side_in.mode = MODE_DIRECT;
            side_in.x    = X_W'(rd_s4_ff[15:0]) << FRAC_BITS;
            side_in.y    = Y_W'(rv_s4_ff[13:0]);
         end else if (dq2_s4_ff > 0) begin
            side_in.mode = MODE_ROOT;
            qnum_in      = QN_W'(dq2_s4_ff[31:0]);
            side_in.v    = rv_s4_ff;
            side_in.a    = ra_s4_ff[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gap_s0_ff <= in_gap;
         sb_s0_ff  <= in_sb;
         vo_s0_ff  <= in_vo;
         ve_s0_ff  <= in_ve;
         ao_s0_ff  <= in_ao;
         ae_s0_ff  <= in_ae;

         rv_s1_ff   <= rv_s1_in;
         rd_s1_ff   <= rd_s1_in;
         ra_s1_ff   <= ra_s1_in;
         b_s1_ff    <= b_s1_in;
         am_s1_ff   <= am_s1_in;
         flag_s1_ff <= flag_s1_in;
         vo_s1_ff   <= vo_s0_ff;
         ve_s1_ff   <= ve_s0_ff;
         ao_s1_ff   <= ao_adj;
         ae_s1_ff   <= ae_s0_ff;
         sb_s1_ff   <= sb_s0_ff;

         vovo_s2_ff <= vovo_s2_in;
         veve_s2_ff <= veve_s2_in;
         vevo_s2_ff <= vevo_s2_in;
         amve_s2_ff <= amve_s2_in;
         aevo_s2_ff <= aevo_s2_in;
         veao_s2_ff <= veao_s2_in;
         sbam_s2_ff <= sbam_s2_in;
         rdam_s2_ff <= rdam_s2_in;
         rvrv_s2_ff <= rvrv_s2_in;
         rard_s2_ff <= rard_s2_in;
         bb_s2_ff   <= bb_s2_in;
         ao_s2_ff   <= ao_s1_ff;
         ae_s2_ff   <= ae_s1_ff;
         am_s2_ff   <= am_s1_ff;
         b_s2_ff    <= b_s1_ff;
         ra_s2_ff   <= ra_s1_ff;
         rd_s2_ff   <= rd_s1_ff;
         rv_s2_ff   <= rv_s1_ff;
         ve_s2_ff   <= ve_s1_ff;
         flag_s2_ff <= flag_s1_ff;

         t1_ff       <= t1_in;
         t2_ff       <= t2_in;
         t3_ff       <= t3_in;
         t4_ff       <= t4_in;
         t5_ff       <= t5_in;
         t6_ff       <= t6_in;
         t7_ff       <= t7_in;
         t8_ff       <= t8_in;
         t9_ff       <= t9_in;
         t10_ff      <= t10_in;
         ovt_s3_ff   <= ovt_s3_in;
         dq2_s3_ff   <= dq2_s3_in;
         ennum_s3_ff <= ennum_s3_in;
         amve2_s3_ff <= amve2_s3_in;
         flag_s3_ff  <= flag_s2_ff;
         rd_s3_ff    <= rd_s2_ff;
         rv_s3_ff    <= rv_s2_ff;
         ra_s3_ff    <= ra_s2_ff;
         ve_s3_ff    <= ve_s2_ff;
         ae_s3_ff    <= ae_s2_ff;
         am_s3_ff    <= am_s2_ff;

         lhs_ff      <= lhs_in;
         rhs_ff      <= rhs_in;
         dq1_ff      <= dq1_in;
         blhs_ff     <= blhs_in;
         brhs_ff     <= brhs_in;
         dq2_s4_ff   <= dq2_s3_ff;
         ennum_s4_ff <= ennum_s3_ff;
         amve2_s4_ff <= amve2_s3_ff;
         flag_s4_ff  <= flag_s3_ff;
         ovt_s4_ff   <= ovt_s3_ff;
         rd_s4_ff    <= rd_s3_ff;
         rv_s4_ff    <= rv_s3_ff;
         ra_s4_ff    <= ra_s3_ff;
         ve_s4_ff    <= ve_s3_ff;
         ae_s4_ff    <= ae_s3_ff;
         am_s4_ff    <= am_s3_ff;

         qnum_ff <= qnum_in;
         qden_ff <= qden_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_qnum  = qnum_ff;
   assign out_qden  = qden_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/core/ttc_qdiv.sv
module ttc_qdiv import ttc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [QN_W-1:0] in_num,
   input  logic [QD_W-1:0] in_den,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [Q_W-1:0]  out_quot,
   output side_type        out_side
);

   // Restoring divide, one quotient bit per stage. The dividend shifts out
   // of the top of the word while quotient bits shift in at the bottom.
   localparam int STAGES = Q_W;

   logic            valid_ff [STAGES];
   logic [QD_W-1:0] rem_ff   [STAGES];
   logic [Q_W-1:0]  word_ff  [STAGES];
   logic [QD_W-1:0] den_ff   [STAGES];
   side_type        side_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic            valid_prev;
      logic [QD_W-1:0] rem_prev, den_prev;
      logic [Q_W-1:0]  word_prev;
      side_type        side_prev;
      logic [QD_W:0]   trial;
      logic            take;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign word_prev  = {in_num, {(2 * GUARD_BITS){1'b0}}};
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign word_prev  = word_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      assign trial = {rem_prev, word_prev[Q_W-1]};
      assign take  = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? QD_W'(trial - {1'b0, den_prev}) : QD_W'(trial);
            word_ff[k] <= {word_prev[Q_W-2:0], take};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = word_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

FILE: rtl/core/ttc_sqrt.sv
module ttc_sqrt import ttc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [Q_W-1:0]  in_value,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [SQ_W-1:0] out_root,
   output side_type        out_side
);

   // Digit-by-digit integer square root, one root bit per stage.
   localparam int STAGES = SQ_W;
   localparam int XW     = 2 * SQ_W;
   localparam int REM_W  = SQ_W + 2;

   logic             valid_ff [STAGES];
   logic [REM_W-1:0] rem_ff   [STAGES];
   logic [SQ_W-1:0]  root_ff  [STAGES];
   logic [XW-1:0]    xw_ff    [STAGES];
   side_type         side_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic             valid_prev;
      logic [REM_W-1:0] rem_prev;
      logic [SQ_W-1:0]  root_prev;
      logic [XW-1:0]    xw_prev;
      side_type         side_prev;
      logic [REM_W+1:0] rem2;
      logic [REM_W+1:0] trial;
      logic             take;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign xw_prev    = XW'(in_value);
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign xw_prev    = xw_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      assign rem2  = {rem_prev, xw_prev[XW-1:XW-2]};
      assign trial = {2'b00, root_prev, 2'b01};
      assign take  = rem2 >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? REM_W'(rem2 - trial) : REM_W'(rem2);
            root_ff[k] <= {root_prev[SQ_W-2:0], take};
            xw_ff[k]   <= {xw_prev[XW-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

FILE: rtl/core/ttc_fdiv.sv
module ttc_fdiv import ttc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_root,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [TIME_W-1:0] out_time,
   output logic              out_inf
);

   localparam int STAGES = TIME_W;
   localparam int N_W    = SQ_W + 2;
   localparam int HI_W   = X_W - TIME_W;

   // Stage A: root numerator for quadratic items; other items pass x and y on.
   logic               valid_a_ff;
   logic [1:0]         mode_a_ff;
   logic [X_W-1:0]     x_a_in, x_a_ff;
   logic [Y_W-1:0]     y_a_in, y_a_ff;
   logic signed [N_W-1:0] n_val;

   // Stage B: saturation test and divider seed.
   logic               valid_b_ff, sat_b_ff, inf_b_ff;
   logic               sat_b_in;
   logic [Y_W-1:0]     rem_b_ff, y_b_ff;
   logic [TIME_W-1:0]  word_b_ff;

   logic               valid_ff [STAGES];
   logic [Y_W-1:0]     rem_ff   [STAGES];
   logic [TIME_W-1:0]  word_ff  [STAGES];
   logic [Y_W-1:0]     y_ff     [STAGES];
   logic               sat_ff   [STAGES];
   logic               inf_ff   [STAGES];

   assign n_val = $signed({2'b00, in_root})
                - $signed({{(N_W - V_W - GUARD_BITS){in_side.v[V_W-1]}},
                           in_side.v, {GUARD_BITS{1'b0}}});

   always_comb begin
      x_a_in = in_side.x;
      y_a_in = in_side.y;
      if (in_side.mode == MODE_ROOT) begin
         if (n_val <= 0) begin
            x_a_in = '0;
            y_a_in = Y_W'(1);
         end else begin
            x_a_in = X_W'(n_val[N_W-2:0]);
            y_a_in = Y_W'(in_side.a);
         end
      end
   end

   assign sat_b_in = {{(Y_W - HI_W){1'b0}}, x_a_ff[X_W-1:TIME_W]} >= y_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_a_ff <= in_side.mode;
         x_a_ff    <= x_a_in;
         y_a_ff    <= y_a_in;
         sat_b_ff  <= sat_b_in;
         inf_b_ff  <= mode_a_ff == MODE_INF;
         rem_b_ff  <= sat_b_in ? '0 : Y_W'(x_a_ff[X_W-1:TIME_W]);
         word_b_ff <= x_a_ff[TIME_W-1:0];
         y_b_ff    <= y_a_ff;
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic              valid_prev, sat_prev, inf_prev;
      logic [Y_W-1:0]    rem_prev, y_prev;
      logic [TIME_W-1:0] word_prev;
      logic [Y_W:0]      trial;
      logic              take;

      if (k == 0) begin : g_first
         assign valid_prev = valid_b_ff;
         assign rem_prev   = rem_b_ff;
         assign word_prev  = word_b_ff;
         assign y_prev     = y_b_ff;
         assign sat_prev   = sat_b_ff;
         assign inf_prev   = inf_b_ff;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign word_prev  = word_ff[k-1];
         assign y_prev     = y_ff[k-1];
         assign sat_prev   = sat_ff[k-1];
         assign inf_prev   = inf_ff[k-1];
      end

      assign trial = {rem_prev, word_prev[TIME_W-1]};
      assign take  = trial >= {1'b0, y_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? Y_W'(trial - {1'b0, y_prev}) : Y_W'(trial);
            word_ff[k] <= {word_prev[TIME_W-2:0], take};
            y_ff[k]    <= y_prev;
            sat_ff[k]  <= sat_prev;
            inf_ff[k]  <= inf_prev;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_inf   = inf_ff[STAGES-1];
   assign out_time  = (inf_ff[STAGES-1] || sat_ff[STAGES-1]) ? '1 : word_ff[STAGES-1];

endmodule

FILE: rtl/core/accel_time_to_collision_core.sv
// Channel   Direction  Signals                         Contents
// req       in         req_tvalid/tready/tdata[71:0]   gap, speeds, accelerations
// rsp       out        rsp_tvalid/tready/tdata/tuser   collision time, infinite flag
// csr       in         csr_valid/ready/wdata[15:0]     safety gap register
//
// One transaction enters per cycle while req_tready is high, and its result
// passes through six front-end stages, 59 stages of the discriminant
// divider, 30 stages of the square root, two finishing stages, 16 stages of the
// final divider and the output register. Reset is synchronous and clears only
// valid bits and the safety gap. A stall on rsp freezes the whole pipeline at
// once, so no transaction is dropped or repeated; req_tready is low only while
// a result waits in the output register and rsp_tready is low.
module accel_time_to_collision_core import ttc_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] distance_gap, [29:16] object_speed, [42:30] object_accel,
   // [56:43] ego_speed, [69:57] ego_accel, [71:70] zero.
   input  logic [71:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] collision_time.
   output logic [15:0] rsp_tdata,
   // [0] never_collides.
   output logic        rsp_tuser,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   logic              advance;
   logic [GAP_W-1:0]  safety_gap_ff, safety_gap_in;

   logic              fe_valid;
   logic [QN_W-1:0]   fe_qnum;
   logic [QD_W-1:0]   fe_qden;
   side_type          fe_side;

   logic              qd_valid;
   logic [Q_W-1:0]    qd_quot;
   side_type          qd_side;

   logic              sq_valid;
   logic [SQ_W-1:0]   sq_root;
   side_type          sq_side;

   logic              fd_valid;
   logic [TIME_W-1:0] fd_time;
   logic              fd_inf;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_time_ff;
   logic              rsp_inf_ff;

   // The whole pipeline moves whenever the output register can take a word.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Always writable; user must change register only while block is idle, unchecked.
   assign csr_ready     = 1'b1;
   assign safety_gap_in = csr_valid ? csr_wdata : safety_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         safety_gap_ff <= '0;
      end else begin
         safety_gap_ff <= safety_gap_in;
      end
   end

   // Differences, products and case selection.
   ttc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_gap    (req_tdata[15:0]),
      .in_vo     (req_tdata[29:16]),
      .in_ao     ($signed(req_tdata[42:30])),
      .in_ve     (req_tdata[56:43]),
      .in_ae     ($signed(req_tdata[69:57])),
      .in_sb     (safety_gap_ff),
      .out_valid (fe_valid),
      .out_qnum  (fe_qnum),
      .out_qden  (fe_qden),
      .out_side  (fe_side)
   );

   // Scaled discriminant divided by its denominator.
   ttc_qdiv u_qdiv (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fe_valid),
      .in_num    (fe_qnum),
      .in_den    (fe_qden),
      .in_side   (fe_side),
      .out_valid (qd_valid),
      .out_quot  (qd_quot),
      .out_side  (qd_side)
   );

   // Integer square root of the discriminant.
   ttc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (qd_valid),
      .in_value  (qd_quot),
      .in_side   (qd_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Root numerator, saturation and the final divide for every case.
   ttc_fdiv u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (fd_valid),
      .out_time  (fd_time),
      .out_inf   (fd_inf)
   );

   assign rsp_valid_in = advance ? fd_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_time_ff <= fd_time;
         rsp_inf_ff  <= fd_inf;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_time_ff;
   assign rsp_tuser  = rsp_inf_ff;

endmodule
